[hdl/tos_pkg.sv]
// Shared types and constants for the TCP option scanner.
// Depends on nothing; used by the walk logic, the top level and the checker.
package tos_pkg;

    // Option kinds and field values on the wire
    localparam logic [7:0] KIND_EOL    = 8'd0;
    localparam logic [7:0] KIND_NOP    = 8'd1;
    localparam logic [7:0] KIND_TS     = 8'd8;
    localparam logic [7:0] KIND_MPTCP  = 8'd30;
    localparam logic [7:0] TS_LEN      = 8'd10;
    localparam logic [7:0] MIN_OPT_LEN = 8'd2;
    localparam logic [3:0] MP_SUB_JOIN = 4'd1;

    // Fixed TCP header size, the echo reply's place in a timestamp option, body indices
    localparam logic [5:0] BASE_HDR_BYTES = 6'd20;
    localparam logic [3:0] MIN_HDR_WORDS  = 4'd5;
    localparam logic [5:0] ECR_REL_OFFSET = 6'd5;
    localparam logic [5:0] ECR_FIRST_IDX  = 6'd6;
    localparam logic [5:0] ECR_LAST_IDX   = 6'd9;
    localparam logic [5:0] MP_SUB_IDX     = 6'd2;
    localparam logic [5:0] BODY_FIRST_IDX = 6'd2;

    typedef struct packed {
        logic       start_req;
        logic [3:0] header_words;
        logic [7:0] opt_byte;
    } t_in_item;

    typedef struct packed {
        logic        done_res;
        logic        is_mptcp;
        logic        is_mpjoin;
        logic        ecr_found;
        logic [31:0] ecr_value;
        logic [5:0]  ecr_offset;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_KIND = 3'b001,
        PH_LEN  = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    typedef struct packed {
        logic mp;
        logic mpjoin;
        logic ts_seen;
        logic ecr_ok;
    } t_flags;

    typedef struct packed {
        logic [5:0]  byte_pos;
        logic [5:0]  area_len;
        t_phase      phase;
        logic [7:0]  cur_kind;
        logic [5:0]  bytes_left;
        logic [5:0]  byte_idx;
        logic        stopped;
        t_flags      flags;
        logic [31:0] echo_reply;
        logic [5:0]  echo_offset;
    } t_walk_state;

    localparam t_walk_state WALK_RESET = '{
        byte_pos:    6'd0,
        area_len:    6'd0,
        phase:       PH_KIND,
        cur_kind:    8'd0,
        bytes_left:  6'd0,
        byte_idx:    6'd0,
        stopped:     1'b0,
        flags:       '0,
        echo_reply:  32'd0,
        echo_offset: 6'd0
    };

endpackage

[hdl/tos_walk.sv]
// Next-state and result logic for one options byte of the TCP option scanner.
// Depends on tos_pkg; purely combinational, registered by the top level.
module tos_walk
    import tos_pkg::*;
(
    input  t_walk_state i_state,
    input  t_in_item    i_item,
    output t_walk_state o_state,
    output t_out_item   o_result
);

    t_walk_state cur;
    t_walk_state nxt;
    logic        done;
    logic        target;
    logic [5:0]  rem;
    logic [7:0]  b;

    always_comb begin
        b      = i_item.opt_byte;
        target = 1'b0;
        done   = 1'b0;

        // Restart the walk on a start transaction, abandoning any area in progress
        cur = i_state;
        if (i_item.start_req) begin
            cur = WALK_RESET;
            if (i_item.header_words >= MIN_HDR_WORDS) begin
                cur.area_len = {i_item.header_words, 2'b00} - BASE_HDR_BYTES;
            end else begin
                cur.area_len = 6'd0;
            end
        end

        rem = cur.area_len - cur.byte_pos;
        nxt = cur;

        if (cur.byte_pos >= cur.area_len) begin
            // Outside an area: only an empty-area start is answered
            done = i_item.start_req;
        end else begin
            // Advance the walk unless it has already stopped
            if (!cur.stopped) begin
                case (cur.phase)
                    PH_KIND: begin
                        if (b == KIND_EOL) begin
                            nxt.stopped = 1'b1;
                        end else if (b == KIND_NOP) begin
                            nxt.stopped = cur.stopped;
                        end else if (rem <= 6'd1) begin
                            nxt.stopped = 1'b1;
                        end else begin
                            nxt.cur_kind   = b;
                            nxt.bytes_left = rem;
                            nxt.phase      = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (b < MIN_OPT_LEN || b > {2'b00, cur.bytes_left}) begin
                            nxt.stopped = 1'b1;
                        end else begin
                            // Latch only the first complete option of each kind
                            if (cur.cur_kind == KIND_MPTCP && !cur.flags.mp) begin
                                nxt.flags.mp = 1'b1;
                                target       = 1'b1;
                            end else if (cur.cur_kind == KIND_TS && !cur.flags.ts_seen) begin
                                nxt.flags.ts_seen = 1'b1;
                                if (b == TS_LEN) begin
                                    nxt.flags.ecr_ok = 1'b1;
                                    nxt.echo_offset  = cur.byte_pos + ECR_REL_OFFSET;
                                    target           = 1'b1;
                                end
                            end
                            nxt.cur_kind   = target ? cur.cur_kind : 8'd0;
                            nxt.bytes_left = b[5:0] - 6'd2;
                            nxt.byte_idx   = BODY_FIRST_IDX;
                            nxt.phase      = (b[5:0] != 6'd2) ? PH_BODY : PH_KIND;
                        end
                    end
                    PH_BODY: begin
                        if (cur.cur_kind == KIND_MPTCP && cur.byte_idx == MP_SUB_IDX
                                && b[7:4] == MP_SUB_JOIN) begin
                            nxt.flags.mpjoin = 1'b1;
                        end
                        if (cur.cur_kind == KIND_TS
                                && cur.byte_idx inside {[ECR_FIRST_IDX:ECR_LAST_IDX]}) begin
                            nxt.echo_reply = {cur.echo_reply[23:0], b};
                        end
                        nxt.byte_idx   = cur.byte_idx + 6'd1;
                        nxt.bytes_left = cur.bytes_left - 6'd1;
                        if (cur.bytes_left == 6'd1) begin
                            nxt.phase = PH_KIND;
                        end
                    end
                    default: begin
                        nxt.stopped = 1'b1;
                    end
                endcase
            end
            nxt.byte_pos = cur.byte_pos + 6'd1;
            done         = (nxt.byte_pos == cur.area_len);
        end

        // Report the findings only on the transaction that closes the area
        o_result = '0;
        if (done) begin
            o_result.done_res  = 1'b1;
            o_result.is_mptcp  = nxt.flags.mp;
            o_result.is_mpjoin = nxt.flags.mpjoin;
            o_result.ecr_found = nxt.flags.ecr_ok;
            if (nxt.flags.ecr_ok) begin
                o_result.ecr_value  = nxt.echo_reply;
                o_result.ecr_offset = nxt.echo_offset;
            end
        end

        o_state = nxt;
    end

endmodule

[hdl/tcp_option_scanner_top.sv]
// Top level of the TCP option scanner: walk state register plus skid-buffered result.
// Depends on tos_pkg and tos_walk.
//
// The scanner takes one TCP options byte per transaction and returns exactly one
// result per input transaction, registered after acceptance. It sustains one byte
// per clock: the whole per-byte option walk is a single combinational update of the
// walk state register, and a two-entry output stage (result register plus skid
// register) keeps accepting while a result waits. The input stalls only when both
// output entries are full. A result carries done_res=1 on the last byte of an
// options area (or on the start transaction of an empty area); all other fields are
// zero until then. There is no reset sweep and no configuration.
module tcp_option_scanner_top
    import tos_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_walk_state r_state;
    t_walk_state n_state;
    t_out_item   n_result;
    t_out_item   r_out;
    t_out_item   r_skid;
    logic        r_out_valid;
    logic        r_skid_valid;
    logic        accept;
    logic        pop;

    tos_walk u_walk (
        .i_state  (r_state),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign o_in_ready  = !r_skid_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign pop         = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Advance the walk state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WALK_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Hold results in the output register, spill to the skid register when stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (!r_out_valid || pop) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end
    end

endmodule

[hdl/tos_checker.sv]
// Port-level checker for the TCP option scanner, bound to the top level.
// Depends on tos_pkg and tcp_option_scanner_top.
module tos_checker
    import tos_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // An accepted transaction leaves a result pending on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("no result pending after accepted transaction");

    // Nothing is reported before the area closes
    a_quiet_until_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res |->
            !o_out_data.is_mptcp && !o_out_data.is_mpjoin && !o_out_data.ecr_found
            && o_out_data.ecr_value == 32'd0 && o_out_data.ecr_offset == 6'd0)
        else $error("findings reported before end of area");

    // Echo reply fields are zero unless a well-formed timestamp was found
    a_ecr_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.ecr_found |->
            o_out_data.ecr_value == 32'd0 && o_out_data.ecr_offset == 6'd0)
        else $error("echo reply reported without timestamp");

    // Echo reply lies inside a 40-byte area, after its option header
    a_ecr_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.ecr_found |->
            o_out_data.ecr_offset >= 6'd5 && o_out_data.ecr_offset <= 6'd39)
        else $error("echo reply offset out of range");

endmodule

bind tcp_option_scanner_top tos_checker u_tos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[verif/tb.sv]
// Self-checking testbench for tcp_option_scanner_top: directed and random options areas.
// Depends on tos_pkg for the transaction structs, phases and option constants.
`timescale 1ns / 100ps

module tb;
    import tos_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int HOLDOFF_LEN  = 80;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Traffic shaping, changed by the test tasks
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int holdoff_len    = 0;

    // Bookkeeping
    t_out_item scan_results_due[$];
    int errors       = 0;
    int quiet_cycles = 0;
    int bytes_sent   = 0;
    int areas_closed = 0;
    int mptcp_hits   = 0;
    int join_hits    = 0;
    int ecr_hits     = 0;

    // Shadow of the option walk
    logic [5:0]  w_pos;
    logic [5:0]  w_len;
    t_phase      w_phase;
    logic [7:0]  w_kind;
    logic [5:0]  w_left;
    logic [5:0]  w_idx;
    logic        w_halt;
    logic        w_mp;
    logic        w_join;
    logic        w_ts;
    logic        w_ecr;
    logic [31:0] w_echo;
    logic [5:0]  w_echo_at;

    tcp_option_scanner_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Clear the walk for a new options area
    function automatic void clear_walk();
        w_pos     = '0;
        w_phase   = PH_KIND;
        w_kind    = '0;
        w_left    = '0;
        w_idx     = '0;
        w_halt    = 1'b0;
        w_mp      = 1'b0;
        w_join    = 1'b0;
        w_ts      = 1'b0;
        w_ecr     = 1'b0;
        w_echo    = '0;
        w_echo_at = '0;
    endfunction

    // Advance the walk by one byte of the area
    function automatic void walk_option_byte(logic [7:0] b);
        logic [5:0] rem;
        logic       hit;
        case (w_phase)
            PH_KIND: begin
                rem = w_len - w_pos;
                if (b == KIND_EOL) begin
                    w_halt = 1'b1;
                end else if (b == KIND_NOP) begin
                    // padding, nothing to record
                end else if (rem <= 6'd1) begin
                    w_halt = 1'b1;
                end else begin
                    w_kind  = b;
                    w_left  = rem;
                    w_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (b < MIN_OPT_LEN || b > {2'b00, w_left}) begin
                    w_halt = 1'b1;
                end else begin
                    hit = 1'b0;
                    if (w_kind == KIND_MPTCP && !w_mp) begin
                        w_mp = 1'b1;
                        hit  = 1'b1;
                    end else if (w_kind == KIND_TS && !w_ts) begin
                        w_ts = 1'b1;
                        if (b == TS_LEN) begin
                            w_ecr     = 1'b1;
                            w_echo_at = w_pos + ECR_REL_OFFSET;
                            hit       = 1'b1;
                        end
                    end
                    if (!hit) w_kind = '0;
                    w_left  = 6'(b - MIN_OPT_LEN);
                    w_idx   = BODY_FIRST_IDX;
                    w_phase = (w_left != 6'd0) ? PH_BODY : PH_KIND;
                end
            end
            PH_BODY: begin
                if (w_kind == KIND_MPTCP && w_idx == MP_SUB_IDX && b[7:4] == MP_SUB_JOIN)
                    w_join = 1'b1;
                if (w_kind == KIND_TS && w_idx >= ECR_FIRST_IDX && w_idx <= ECR_LAST_IDX)
                    w_echo = {w_echo[23:0], b};
                w_idx  = w_idx + 6'd1;
                w_left = w_left - 6'd1;
                if (w_left == 6'd0) w_phase = PH_KIND;
            end
            default: w_halt = 1'b1;
        endcase
    endfunction

    // Work out the result that one input transaction produces
    function automatic t_out_item predict_scan(t_in_item it);
        t_out_item r;
        logic      done;
        r    = '0;
        done = 1'b0;
        if (it.start_req) begin
            clear_walk();
            w_len = (it.header_words >= MIN_HDR_WORDS) ?
                    {it.header_words, 2'b00} - BASE_HDR_BYTES : 6'd0;
        end
        if (w_pos >= w_len) begin
            done = it.start_req;
        end else begin
            if (!w_halt) walk_option_byte(it.opt_byte);
            w_pos = w_pos + 6'd1;
            done  = (w_pos == w_len);
        end
        if (done) begin
            r.done_res   = 1'b1;
            r.is_mptcp   = w_mp;
            r.is_mpjoin  = w_join;
            r.ecr_found  = w_ecr;
            r.ecr_value  = w_ecr ? w_echo : 32'd0;
            r.ecr_offset = w_ecr ? w_echo_at : 6'd0;
        end
        return r;
    endfunction

    // Offer one transaction, idling first as the sender setting asks
    task automatic send_item(input t_in_item it);
        t_out_item due;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        due = predict_scan(it);
        scan_results_due.push_back(due);
        bytes_sent++;
        if (due.done_res) begin
            areas_closed++;
            mptcp_hits += int'(due.is_mptcp);
            join_hits  += int'(due.is_mpjoin);
            ecr_hits   += int'(due.ecr_found);
        end
    endtask

    // Send the first cut bytes of an area; the start transaction always goes out
    task automatic send_segment(input logic [3:0] words, input logic [7:0] area[$],
                                input int cut);
        t_in_item it;
        it.start_req    = 1'b1;
        it.header_words = words;
        it.opt_byte     = (area.size() > 0) ? area[0] : 8'($urandom);
        send_item(it);
        for (int i = 1; i < cut; i++) begin
            it.start_req    = 1'b0;
            it.header_words = 4'($urandom);
            it.opt_byte     = area[i];
            send_item(it);
        end
    endtask

    // Fill an area of len bytes with mostly well-formed options and some breakage
    task automatic build_options(input int len, ref logic [7:0] area[$]);
        int room;
        int olen;
        int pick;
        area.delete();
        while (area.size() < len) begin
            room = len - area.size();
            pick = $urandom_range(99);
            if (pick < 14) begin
                area.push_back(KIND_NOP);
            end else if (pick < 38 && room >= 2) begin
                olen = (room >= 10 && $urandom_range(7) != 0) ? 10 : $urandom_range(2, room);
                area.push_back(KIND_TS);
                area.push_back(8'(olen));
                for (int k = 2; k < olen; k++) area.push_back(8'($urandom));
            end else if (pick < 58 && room >= 2) begin
                olen = $urandom_range(2, (room > 24) ? 24 : room);
                area.push_back(KIND_MPTCP);
                area.push_back(8'(olen));
                for (int k = 2; k < olen; k++) begin
                    if (k == 2)
                        area.push_back({($urandom_range(1) != 0) ? MP_SUB_JOIN : 4'($urandom),
                                        4'($urandom)});
                    else
                        area.push_back(8'($urandom));
                end
            end else if (pick < 74 && room >= 2) begin
                olen = $urandom_range(2, (room > 12) ? 12 : room);
                area.push_back(8'($urandom_range(2, 255)));
                area.push_back(8'(olen));
                for (int k = 2; k < olen; k++) area.push_back(8'($urandom));
            end else if (pick < 79) begin
                area.push_back(KIND_EOL);
            end else if (pick < 88) begin
                // silly length or one that runs past the end
                area.push_back(8'($urandom_range(2, 255)));
                area.push_back(($urandom_range(1) != 0) ? 8'($urandom_range(1)) :
                               8'($urandom_range(room + 1, 255)));
            end else begin
                area.push_back(8'($urandom));
            end
        end
        while (area.size() > len) void'(area.pop_back());
    endtask

    // Lower valid and hold until every result has come back
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [7:0] area[$];
        t_in_item   it;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        // empty area answered on the start transaction
        area = {};
        send_segment(4'd0, area, 0);
        // stray byte outside any area
        it = '{start_req: 1'b0, header_words: 4'hF, opt_byte: 8'hFF};
        send_item(it);
        // multipath join option filling the area
        area = {KIND_MPTCP, 8'd4, 8'h1A, 8'h55};
        send_segment(4'd6, area, area.size());
        // aligned timestamp behind two NOPs
        area = {KIND_NOP, KIND_NOP, KIND_TS, TS_LEN, 8'h11, 8'h22, 8'h33, 8'h44,
                8'hDE, 8'hAD, 8'hBE, 8'hEF};
        send_segment(4'd8, area, area.size());
        // abandon a full-size area after one byte
        area = {KIND_NOP};
        send_segment(4'd15, area, 1);
        // short multipath, short timestamp, EOL, then bytes after the stop
        area = {KIND_MPTCP, 8'd2, KIND_TS, 8'd3, 8'h5A, KIND_EOL, KIND_MPTCP, 8'h1A};
        send_segment(4'd7, area, area.size());
        wait_drain();
    endtask

    task automatic test_random_traffic(input int n_items, input int gap_pct,
                                       input int stall_pct);
        logic [7:0] area[$];
        logic [3:0] words;
        int         len;
        int         cut;
        int         sent;
        t_in_item   it;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            words = ($urandom_range(9) == 0) ? 4'($urandom_range(0, 5)) :
                                               4'($urandom_range(6, 15));
            len = (words >= MIN_HDR_WORDS) ? int'(words) * 4 - 20 : 0;
            build_options(len, area);
            cut = len;
            if (len > 1 && $urandom_range(99) < 8) cut = $urandom_range(1, len - 1);
            send_segment(words, area, cut);
            sent += (cut > 0) ? cut : 1;
            // idle bytes between areas, only after a complete one
            if (cut == len && $urandom_range(99) < 8) begin
                repeat ($urandom_range(1, 3)) begin
                    it = '{start_req: 1'b0, header_words: 4'($urandom),
                           opt_byte: 8'($urandom)};
                    send_item(it);
                end
            end
        end
        wait_drain();
    endtask

    // Stall the result side for a long stretch while the sender keeps offering
    task automatic test_output_holdoff();
        logic [7:0] area[$];
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        holdoff_len    = HOLDOFF_LEN;
        repeat (2) begin
            build_options(40, area);
            send_segment(4'd15, area, area.size());
        end
        wait_drain();
    endtask

    // Pause the sender after each area until all results are back
    task automatic test_sender_pause();
        logic [7:0] area[$];
        logic [3:0] words;
        send_gap_pct   = 17;
        recv_stall_pct = 17;
        repeat (6) begin
            words = 4'($urandom_range(6, 15));
            build_options(int'(words) * 4 - 20, area);
            send_segment(words, area, area.size());
            wait_drain();
        end
    endtask

    // Drive the result side: random stalls, or a counted hold-off when asked
    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if (holdoff_len > 0) begin
                hold        = holdoff_len;
                holdoff_len = 0;
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (scan_results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction: expected none, actual %h",
                         $time, o_out_data);
            end else begin
                want = scan_results_due.pop_front();
                check_field("done_res", 32'(want.done_res), 32'(o_out_data.done_res));
                check_field("is_mptcp", 32'(want.is_mptcp), 32'(o_out_data.is_mptcp));
                check_field("is_mpjoin", 32'(want.is_mpjoin), 32'(o_out_data.is_mpjoin));
                check_field("ecr_found", 32'(want.ecr_found), 32'(o_out_data.ecr_found));
                check_field("ecr_value", want.ecr_value, o_out_data.ecr_value);
                check_field("ecr_offset", 32'(want.ecr_offset), 32'(o_out_data.ecr_offset));
            end
        end
    end

    // Count cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, scan_results_due.size());
        $display("** tcp_option_scanner_top: FAILED **");
        $finish;
    end

    initial begin
        clear_walk();
        w_len = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(170, 0, 0);
        test_random_traffic(170, 68, 0);
        test_random_traffic(170, 0, 68);
        test_random_traffic(170, 17, 17);
        test_output_holdoff();
        test_sender_pause();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (scan_results_due.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     scan_results_due.size());
        end

        $display("Scanned %0d option bytes, %0d areas closed under mixed idle and stall.",
                 bytes_sent, areas_closed);
        $display("Areas with multipath: %0d, with join: %0d, with echo reply: %0d; errors: %0d",
                 mptcp_hits, join_hits, ecr_hits, errors);
        if (errors == 0) begin
            $display("** tcp_option_scanner_top: PASSED **");
        end else begin
            $display("** tcp_option_scanner_top: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
hdl/tos_pkg.sv
hdl/tos_walk.sv
hdl/tcp_option_scanner_top.sv
hdl/tos_checker.sv
verif/tb.sv
